### rtl/core/sjfq_pkg.sv
package sjfq_pkg;

   // Width of the waiting count reported with each result item
   localparam int WAIT_W = 5;

   // Operation codes of an input item
   typedef enum logic [1:0] {
      OP_ENQUEUE = 2'd0,
      OP_SWITCH  = 2'd1,
      OP_TICK    = 2'd2
   } op_type;

   // One ready entry held by a queue cell
   typedef struct packed {
      logic [15:0] proc_id;
      logic [15:0] burst_len;
      logic [31:0] arrival;
   } entry_type;

   // Per-cell control from the sequencer
   typedef struct packed {
      logic write;   // load the enqueued entry
      logic shift;   // take the neighbor's entry (queue rotates toward cell 0)
      logic insert;  // on shift, take the head entry instead (tail of the ring)
   } cell_ctrl_type;

   // Input item
   typedef struct packed {
      logic [1:0]  operation;
      logic [15:0] proc_id;
      logic [15:0] burst_len;
      logic [31:0] arrival;
   } req_type;

   // Result item
   typedef struct packed {
      logic              busy_res;
      logic [15:0]       active_id;
      logic [15:0]       time_left;
      logic              dispatched;
      logic              finished;
      logic [15:0]       finished_id;
      logic [WAIT_W-1:0] waiting;
      logic [31:0]       elapsed;
      logic              rejected;
   } rsp_type;

   // True when entry a goes before entry b: least burst, earliest arrival, smallest id
   function automatic logic prefer(entry_type a, entry_type b);
      logic result;
      if (a.burst_len != b.burst_len) begin
         result = (a.burst_len < b.burst_len);
      end else if (a.arrival != b.arrival) begin
         result = (a.arrival < b.arrival);
      end else begin
         result = (a.proc_id < b.proc_id);
      end
      return result;
   endfunction

endpackage

### rtl/core/sjfq_cell.sv
module sjfq_cell (
   input  logic                  clock,
   input  sjfq_pkg::cell_ctrl_type ctrl,
   input  sjfq_pkg::entry_type   wr_entry,
   input  sjfq_pkg::entry_type   head_entry,
   input  sjfq_pkg::entry_type   next_entry,
   output sjfq_pkg::entry_type   entry
);
   import sjfq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Pick the next content: enqueue load, ring insert, shift from neighbor, or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.write) begin
         entry_in = wr_entry;
      end else if (ctrl.shift) begin
         entry_in = ctrl.insert ? head_entry : next_entry;
      end
   end

   // Hold the entry
   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

### rtl/core/sjf_ready_queue_dispatcher.sv
// Shortest-job-first ready queue dispatcher. Entries sit in a row of QUEUE_DEPTH cells in
// enqueue order, cell 0 at the head. Every input item yields exactly one result item. An
// enqueue, a tick that does not finish its process, an unused code, or a switch or finishing
// tick on an empty queue goes from acceptance to the report state, which loads the result
// register; the next item can be taken once that result is loaded. A switch, or a tick that
// finishes the running process, with entries waiting passes through the scan and drop
// states first: the row rotates once through its head cell while the best entry is tracked,
// then rotates once more and drops that entry, which leaves the rest compacted in their
// original order. The block takes one item at a time; req_stall stays high until the item's
// result is loaded. A loaded result waits for the sink without holding off acceptance of the
// next item, but while it still waits on rsp_stall the next result is not loaded.
module sjf_ready_queue_dispatcher #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  sjfq_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output sjfq_pkg::rsp_type rsp_data
);
   import sjfq_pkg::*;

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DROP,
      S_REPORT
   } state_type;

   state_type     state_ff;
   logic [CW-1:0] slot_count_ff;
   logic [CW-1:0] scan_len_ff;
   logic [CW-1:0] step_ff;
   logic [CW-1:0] best_idx_ff;
   entry_type     best_ff;
   logic          run_valid_ff;
   logic [15:0]   run_id_ff;
   logic [15:0]   run_left_ff;
   logic [31:0]   tick_total_ff;
   logic          dispatched_ff;
   logic          finished_ff;
   logic [15:0]   fin_id_ff;
   logic          rejected_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_data_ff;

   entry_type     cell_q [QUEUE_DEPTH];
   entry_type     head_entry;
   entry_type     wr_entry;
   logic [CW-1:0] tail_idx;
   logic          accept;
   logic          enq_fire;
   logic          rot_en;
   logic          rot_keep;
   logic          last_step;

   assign accept     = (state_ff == S_IDLE) && req_valid;
   assign enq_fire   = accept && (req_data.operation == OP_ENQUEUE)
                       && (slot_count_ff < CW'(QUEUE_DEPTH));
   assign rot_en     = (state_ff == S_SCAN) || (state_ff == S_DROP);
   assign rot_keep   = (state_ff == S_SCAN) || (step_ff != best_idx_ff);
   assign tail_idx   = slot_count_ff - CW'(1);
   assign last_step  = (step_ff == scan_len_ff - CW'(1));
   assign head_entry = cell_q[0];

   assign wr_entry.proc_id   = req_data.proc_id;
   assign wr_entry.burst_len = req_data.burst_len;
   assign wr_entry.arrival   = req_data.arrival;

   // Row of queue cells; each shifts toward the head, the tail cell takes the head back
   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      cell_ctrl_type ctrl;
      entry_type     next_entry;

      assign ctrl.write  = enq_fire && (CW'(g) == slot_count_ff);
      assign ctrl.shift  = rot_en;
      assign ctrl.insert = rot_keep && (CW'(g) == tail_idx);

      if (g < QUEUE_DEPTH - 1) begin : g_mid
         assign next_entry = cell_q[g + 1];
      end else begin : g_end
         assign next_entry = cell_q[g];
      end

      sjfq_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .wr_entry   (wr_entry),
         .head_entry (head_entry),
         .next_entry (next_entry),
         .entry      (cell_q[g])
      );
   end

   // Sequencer: decode items, run the scan and drop passes, load the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         slot_count_ff <= '0;
         run_valid_ff  <= 1'b0;
         run_id_ff     <= '0;
         run_left_ff   <= '0;
         tick_total_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // Drop a taken result unless the report state loads a new one this cycle
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_REPORT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  dispatched_ff <= 1'b0;
                  finished_ff   <= 1'b0;
                  fin_id_ff     <= '0;
                  rejected_ff   <= 1'b0;
                  step_ff       <= '0;
                  scan_len_ff   <= slot_count_ff;
                  state_ff      <= S_REPORT;
                  unique case (req_data.operation)
                     OP_ENQUEUE: begin
                        if (slot_count_ff < CW'(QUEUE_DEPTH)) begin
                           slot_count_ff <= slot_count_ff + CW'(1);
                        end else begin
                           rejected_ff <= 1'b1;
                        end
                     end
                     OP_SWITCH: begin
                        finished_ff  <= run_valid_ff;
                        fin_id_ff    <= run_valid_ff ? run_id_ff : 16'd0;
                        run_valid_ff <= 1'b0;
                        run_id_ff    <= '0;
                        run_left_ff  <= '0;
                        if (slot_count_ff != '0) begin
                           state_ff <= S_SCAN;
                        end
                     end
                     OP_TICK: begin
                        tick_total_ff <= tick_total_ff + 32'd1;
                        if (run_valid_ff) begin
                           if (run_left_ff <= 16'd1) begin
                              finished_ff  <= 1'b1;
                              fin_id_ff    <= run_id_ff;
                              run_valid_ff <= 1'b0;
                              run_id_ff    <= '0;
                              run_left_ff  <= '0;
                              if (slot_count_ff != '0) begin
                                 state_ff <= S_SCAN;
                              end
                           end else begin
                              run_left_ff <= run_left_ff - 16'd1;
                           end
                        end
                     end
                     default: begin
                        // unused code: report status only
                     end
                  endcase
               end
            end
            S_SCAN: begin
               // Track the best entry as the row rotates past the head; first wins ties
               if ((step_ff == '0) || prefer(head_entry, best_ff)) begin
                  best_ff     <= head_entry;
                  best_idx_ff <= step_ff;
               end
               if (last_step) begin
                  step_ff  <= '0;
                  state_ff <= S_DROP;
               end else begin
                  step_ff <= step_ff + CW'(1);
               end
            end
            S_DROP: begin
               // Drop the best entry as it leaves the head; others return to the tail
               if (step_ff == best_idx_ff) begin
                  slot_count_ff <= slot_count_ff - CW'(1);
               end
               if (last_step) begin
                  run_valid_ff  <= 1'b1;
                  run_id_ff     <= best_ff.proc_id;
                  run_left_ff   <= best_ff.burst_len;
                  dispatched_ff <= 1'b1;
                  state_ff      <= S_REPORT;
               end else begin
                  step_ff <= step_ff + CW'(1);
               end
            end
            S_REPORT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff             <= 1'b1;
                  rsp_data_ff.busy_res     <= run_valid_ff;
                  rsp_data_ff.active_id    <= run_id_ff;
                  rsp_data_ff.time_left    <= run_left_ff;
                  rsp_data_ff.dispatched   <= dispatched_ff;
                  rsp_data_ff.finished     <= finished_ff;
                  rsp_data_ff.finished_id  <= fin_id_ff;
                  rsp_data_ff.waiting      <= WAIT_W'(slot_count_ff);
                  rsp_data_ff.elapsed      <= tick_total_ff;
                  rsp_data_ff.rejected     <= rejected_ff;
                  state_ff                 <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef ASSERT_OFF
   // Queue occupancy never passes the depth
   assert property (@(posedge clock) disable iff (reset)
      slot_count_ff <= CW'(QUEUE_DEPTH))
      else $error("queue count above depth");

   // An accepted item raises req_stall in the cycle after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("item accepted while previous item in progress");

   // An idle result reports no running id and no remaining time
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.busy_res) |->
         (rsp_data.active_id == 16'd0 && rsp_data.time_left == 16'd0))
      else $error("idle result carries running process fields");

   // A finished id appears only with the finished flag
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.finished) |-> (rsp_data.finished_id == 16'd0))
      else $error("finished id without finished flag");

   // Dispatch leaves a running process behind
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.dispatched) |-> rsp_data.busy_res)
      else $error("dispatch without running process");
`endif

endmodule
